// ===== src/pi_controller_with_limits_defines.svh =====
// assertion macros for the pi controller
`ifndef PI_CONTROLLER_WITH_LIMITS_DEFINES_SVH
`define PI_CONTROLLER_WITH_LIMITS_DEFINES_SVH

// property checked on every clock edge out of reset
`define PICC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// antecedent this cycle, consequent in the next one
`define PICC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PICC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/picc_pkg.sv =====
// shared types, constants and arithmetic helpers for the pi controller
`default_nettype none
package picc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int MAG_W          = 36;
  localparam int GAIN_W         = 32;
  localparam int PROD_W         = 68;
  localparam int WIDE_W         = 56;
  localparam int ADDR_W         = 5;

  localparam logic [1:0] MODE_DAMPED = 2'd0;
  localparam logic [1:0] MODE_PI     = 2'd1;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN = 3'd1;
  localparam logic [2:0] REG_INT_GAIN  = 3'd2;
  localparam logic [2:0] REG_DAMPING   = 3'd3;
  localparam logic [2:0] REG_LIMIT     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAMP,
    ST_INTG,
    ST_PROP,
    ST_DONE
  } picc_state_t;

  typedef struct packed {
    logic load;
    logic damp;
    logic intg;
    logic prop;
    logic finish;
  } picc_cmd_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] prop_gain;
    logic [31:0] int_gain_dt;
    logic [17:0] damping;
    logic [30:0] limit;
  } picc_cfg_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
    logic signed [MAG_W-1:0] n;
    n = -v;
    return v[MAG_W-1] ? $unsigned(n) : $unsigned(v);
  endfunction

  // round half up on the magnitude, then drop the fraction
  function automatic logic [WIDE_W-2:0] round_shift(input logic [PROD_W-1:0] p,
                                                     input logic wide_frac);
    logic [PROD_W-1:0] t;
    if (wide_frac) begin
      t = (p + (PROD_W'(1) << 23)) >> 24;
    end else begin
      t = (p + (PROD_W'(1) << 15)) >> 16;
    end
    return t[WIDE_W-2:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] with_sign(input logic [WIDE_W-2:0] m,
                                                         input logic neg);
    logic signed [WIDE_W-1:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

endpackage
`default_nettype wire

// ===== src/picc_regs.sv =====
// configuration registers behind the apb-style port
`default_nettype none
module picc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [picc_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready,
  output picc_pkg::picc_cfg_t                cfg
);

  picc_pkg::picc_cfg_t cfg_r, cfg_nxt;
  logic [2:0]          idx;
  logic                wr;

  assign idx        = cfg_paddr[picc_pkg::ADDR_W-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        picc_pkg::REG_MODE:      cfg_nxt.mode        = cfg_pwdata[1:0];
        picc_pkg::REG_PROP_GAIN: cfg_nxt.prop_gain   = cfg_pwdata;
        picc_pkg::REG_INT_GAIN:  cfg_nxt.int_gain_dt = cfg_pwdata;
        picc_pkg::REG_DAMPING:   cfg_nxt.damping     = cfg_pwdata[17:0];
        picc_pkg::REG_LIMIT:     cfg_nxt.limit       = cfg_pwdata[30:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      picc_pkg::REG_MODE:      cfg_prdata = 32'(cfg_r.mode);
      picc_pkg::REG_PROP_GAIN: cfg_prdata = cfg_r.prop_gain;
      picc_pkg::REG_INT_GAIN:  cfg_prdata = cfg_r.int_gain_dt;
      picc_pkg::REG_DAMPING:   cfg_prdata = 32'(cfg_r.damping);
      picc_pkg::REG_LIMIT:     cfg_prdata = 32'(cfg_r.limit);
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= picc_pkg::MODE_DAMPED;
      cfg_r.prop_gain   <= 32'd65536;
      cfg_r.int_gain_dt <= 32'd0;
      cfg_r.damping     <= 18'd65536;
      cfg_r.limit       <= 31'h7FFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/picc_mul.sv =====
// shared magnitude multiplier: 32x32 core plus a narrow top slice
`default_nettype none
module picc_mul (
  input  wire logic [picc_pkg::MAG_W-1:0]  a,
  input  wire logic [picc_pkg::GAIN_W-1:0] b,
  output logic      [picc_pkg::PROD_W-1:0] p
);

  localparam int TOP_W = picc_pkg::MAG_W - 32;

  logic [63:0]                  lo;
  logic [TOP_W+picc_pkg::GAIN_W-1:0] hi;

  assign lo = a[31:0] * b;
  assign hi = a[picc_pkg::MAG_W-1:32] * b;
  assign p  = (picc_pkg::PROD_W'(hi) << 32) + picc_pkg::PROD_W'(lo);

endmodule
`default_nettype wire

// ===== src/picc_dp.sv =====
// datapath: operand select, shared multiplier, integral and result registers
`default_nettype none
module picc_dp #(
  parameter int DATA_WIDTH = picc_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire picc_pkg::picc_cmd_t             cmd,
  input  wire picc_pkg::picc_cfg_t             cfg,
  input  wire logic signed [picc_pkg::FIELD_W-1:0] in_reference,
  input  wire logic signed [picc_pkg::FIELD_W-1:0] in_feedback,
  output logic signed [picc_pkg::FIELD_W-1:0]  out_drive,
  output logic signed [picc_pkg::FIELD_W-1:0]  out_integral_now,
  output logic                                 out_limited
);

  localparam int SIG_W  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int MAG_W  = picc_pkg::MAG_W;
  localparam int WIDE_W = picc_pkg::WIDE_W;
  localparam int FW     = picc_pkg::FIELD_W;

  localparam logic signed [WIDE_W-1:0] SIG_MAX =
    $signed({{(WIDE_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] SIG_MIN =
    $signed({{(WIDE_W-SIG_W+1){1'b1}}, {(SIG_W-1){1'b0}}});

  logic signed [FW-1:0]     ref_r, fb_r;
  logic [picc_pkg::PROD_W-1:0] prod_r, prod;
  logic                     neg_r, neg_nxt;
  logic signed [MAG_W-1:0]  path_r;
  logic signed [SIG_W-1:0]  sum_r, integ_r;
  logic signed [FW-1:0]     drive_r, integ_out_r;
  logic                     limited_r;

  logic signed [MAG_W-1:0]  ref_x, fb_x, err_x, op_s;
  logic [picc_pkg::GAIN_W-1:0] op_b;
  logic signed [WIDE_W-1:0] rnd_s, fb_w, integ_w, sum_w, lim_p, lim_n;
  logic signed [WIDE_W-1:0] clamp_sum, pd, d_pre, d_sat, drive_w, integ_new;
  logic                     hit_sum, hit;

  function automatic logic signed [WIDE_W-1:0] sat_sig(input logic signed [WIDE_W-1:0] v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  assign ref_x = MAG_W'(ref_r);
  assign fb_x  = MAG_W'(fb_r);
  assign err_x = ref_x - fb_x;

  always_comb begin
    op_s = ref_x;
    op_b = picc_pkg::GAIN_W'(cfg.damping);
    if (cmd.intg) begin
      op_s = err_x;
      op_b = cfg.int_gain_dt;
    end else if (cmd.prop) begin
      op_s = path_r;
      op_b = cfg.prop_gain;
    end
    neg_nxt = op_s[MAG_W-1];
  end

  picc_mul u_mul (
    .a (picc_pkg::mag_of(op_s)),
    .b (op_b),
    .p (prod)
  );

  // the integral product carries a 24-bit fraction, the others 16
  assign rnd_s   = picc_pkg::with_sign(picc_pkg::round_shift(prod_r, cmd.prop), neg_r);
  assign fb_w    = WIDE_W'(fb_r);
  assign integ_w = WIDE_W'(integ_r);
  assign sum_w   = WIDE_W'(sum_r);
  assign lim_p   = $signed({{(WIDE_W-31){1'b0}}, cfg.limit});
  assign lim_n   = -lim_p;

  always_comb begin
    clamp_sum = sum_w;
    hit_sum   = 1'b0;
    if (sum_w > lim_p) begin
      clamp_sum = lim_p;
      hit_sum   = 1'b1;
    end else if (sum_w < lim_n) begin
      clamp_sum = lim_n;
      hit_sum   = 1'b1;
    end
    pd    = rnd_s;
    d_pre = sat_sig(pd + ((cfg.mode == picc_pkg::MODE_DAMPED) ? clamp_sum : sum_w));
    d_sat = sat_sig(pd + sum_w);
    case (cfg.mode)
      picc_pkg::MODE_DAMPED: begin
        integ_new = clamp_sum;
        drive_w   = d_pre;
        hit       = hit_sum;
      end
      picc_pkg::MODE_PI: begin
        integ_new = clamp_sum;
        drive_w   = d_pre;
        hit       = hit_sum;
      end
      default: begin
        integ_new = sum_w;
        drive_w   = d_sat;
        hit       = 1'b0;
        if (d_sat > lim_p) begin
          drive_w = lim_p;
          hit     = 1'b1;
        end else if (d_sat < lim_n) begin
          drive_w = lim_n;
          hit     = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ref_r <= in_reference;
      fb_r  <= in_feedback;
    end
    if (cmd.damp || cmd.intg || cmd.prop) begin
      prod_r <= prod;
      neg_r  <= neg_nxt;
    end
    if (cmd.intg) begin
      if (cfg.mode == picc_pkg::MODE_DAMPED) begin
        path_r <= MAG_W'(rnd_s - fb_w);
      end else begin
        path_r <= err_x;
      end
    end
    if (cmd.prop) begin
      sum_r <= SIG_W'(sat_sig(integ_w + rnd_s));
    end
    if (cmd.finish) begin
      drive_r     <= drive_w[FW-1:0];
      integ_out_r <= integ_new[FW-1:0];
      limited_r   <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (cmd.finish) begin
      integ_r <= integ_new[SIG_W-1:0];
    end
  end

  assign out_drive        = drive_r;
  assign out_integral_now = integ_out_r;
  assign out_limited      = limited_r;

endmodule
`default_nettype wire

// ===== src/picc_ctrl.sv =====
// sequencer: steps the shared multiplier and owns both handshakes
`default_nettype none
`include "pi_controller_with_limits_defines.svh"
module picc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output picc_pkg::picc_cmd_t cmd
);

  picc_pkg::picc_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  finishing, take;

  always_comb begin
    // a finished item leaves only once the output register is free
    finishing     = (state_r == picc_pkg::ST_DONE) && !(out_valid_r && out_stall);
    in_stall      = !((state_r == picc_pkg::ST_IDLE) || finishing);
    take          = in_valid && !in_stall;
    out_valid_nxt = finishing || (out_valid_r && out_stall);
    state_nxt     = state_r;
    cmd.load      = take;
    cmd.damp      = (state_r == picc_pkg::ST_DAMP);
    cmd.intg      = (state_r == picc_pkg::ST_INTG);
    cmd.prop      = (state_r == picc_pkg::ST_PROP);
    cmd.finish    = finishing;
    case (state_r)
      picc_pkg::ST_IDLE: begin
        if (take) state_nxt = picc_pkg::ST_DAMP;
      end
      picc_pkg::ST_DAMP: state_nxt = picc_pkg::ST_INTG;
      picc_pkg::ST_INTG: state_nxt = picc_pkg::ST_PROP;
      picc_pkg::ST_PROP: state_nxt = picc_pkg::ST_DONE;
      picc_pkg::ST_DONE: begin
        if (finishing) state_nxt = take ? picc_pkg::ST_DAMP : picc_pkg::ST_IDLE;
      end
      default: state_nxt = picc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= picc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PICC_ASSERT(a_busy_stalls, ((state_r == picc_pkg::ST_DAMP) || (state_r == picc_pkg::ST_INTG) || (state_r == picc_pkg::ST_PROP)) |-> in_stall, "input taken mid-computation")
  `PICC_ASSERT_NEXT(a_take_starts, in_valid && !in_stall, state_r == picc_pkg::ST_DAMP, "accepted item did not start")
  `PICC_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == picc_pkg::ST_DONE), "result without a finished item")
  `PICC_ASSERT_NEXT(a_done_blocked, (state_r == picc_pkg::ST_DONE) && out_valid_r && out_stall, state_r == picc_pkg::ST_DONE, "finished item overran a waiting result")

endmodule
`default_nettype wire

// ===== src/pi_controller_with_limits.sv =====
// top level of the pi controller with anti-windup limits
//
// Input channel: in_reference and in_feedback (signed Q16.16) with
// in_valid / in_stall; an item is taken on a clock edge with valid high
// and stall low. Result channel: out_drive, out_integral_now and
// out_limited with out_valid / out_stall, same rule.
// Each item is stepped through the one shared multiplier (damped
// reference, integral increment, proportional term), then through the
// sums, saturation and clamp. The result is registered at the end of
// that final step, and a new item can be taken during it, so the next
// item starts while the one before it finishes.
// The result register lets the next item start while a result waits;
// if the receiver still stalls when that item is done, the block holds
// it in its last step and stalls the input until the result is taken.
// Reset (rst_n low, synchronous) clears the integral, empties the
// result register and loads the register defaults. Registers are set
// through the cfg_ port, one word each at byte address 4*index; the user
// must do so while no item is in flight, which the block does not enforce.
`default_nettype none
module pi_controller_with_limits #(
  parameter int DATA_WIDTH = picc_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [picc_pkg::FIELD_W-1:0] in_reference,
  input  wire logic signed [picc_pkg::FIELD_W-1:0] in_feedback,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [picc_pkg::FIELD_W-1:0]      out_drive,
  output logic signed [picc_pkg::FIELD_W-1:0]      out_integral_now,
  output logic                                     out_limited,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [picc_pkg::ADDR_W-1:0]         cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic      [31:0]                         cfg_prdata,
  output logic                                     cfg_pready
);

  picc_pkg::picc_cfg_t cfg;
  picc_pkg::picc_cmd_t cmd;

  picc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  picc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  picc_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_reference     (in_reference),
    .in_feedback      (in_feedback),
    .out_drive        (out_drive),
    .out_integral_now (out_integral_now),
    .out_limited      (out_limited)
  );

endmodule
`default_nettype wire
